// ===== rtl/cst_pkg.sv =====
// Package for the CIGAR string tokenizer: operation and error codes and the
// ASCII character constants used by the decoder. No dependencies.
package cst_pkg;

    // Operation codes as carried on the result channel.
    typedef enum logic [2:0] {
        OP_M = 3'd0,
        OP_I = 3'd1,
        OP_D = 3'd2,
        OP_N = 3'd3,
        OP_S = 3'd4
    } t_op_code;

    // Error codes as carried on the result channel.
    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_LENGTH = 3'd1,
        ERR_CODE   = 3'd2,
        ERR_INDEL  = 3'd3,
        ERR_OPS    = 3'd4
    } t_err_code;

    // ASCII characters recognised in a CIGAR string.
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_S    = 8'h53;

    // Widths of the fixed result fields.
    localparam int OUT_LEN_BITS = 28;
    localparam int COUNT_BITS   = 9;

endpackage

// ===== rtl/cigar_string_tokenizer_top.sv =====
// CIGAR string tokenizer: one character per request in, at most one decoded
// operation per request out. Depends on cst_pkg.
//
// Usage:
//   The input channel (i_valid / o_ready) carries one ASCII character of a
//   CIGAR string per request, with i_first_char marking the start of a string
//   (which also samples i_start_position and i_allow_indels) and i_last_char
//   marking its end. Digits build a run length; each code letter produces one
//   request on the output channel (o_valid / i_ready) holding the length, the
//   code, the reference start, the operation index and the running N count.
//   An error produces one result with a non-zero error code and last_op set,
//   after which the rest of the string is ignored until the next first_char.
// Timing:
//   Characters are registered on entry and decoded from the input register
//   into the result register, which presents each result. One character is
//   accepted every cycle while the result register is free; the rate is set
//   by the update of the run length and position registers in the decode stage.
// Reset and stalls:
//   After reset the block ignores characters until one carries i_first_char.
//   When the receiver holds i_ready low with a result waiting, the input
//   register still fills; o_ready then falls until the result is taken.
module cigar_string_tokenizer_top
    import cst_pkg::*;
#(
    parameter int MAX_OPS     = 256,
    parameter int LENGTH_BITS = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_character,
    input  logic        i_first_char,
    input  logic        i_last_char,
    input  logic [31:0] i_start_position,
    input  logic        i_allow_indels,
    // Output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [27:0] o_op_length,
    output logic [2:0]  o_op_code,
    output logic [31:0] o_ref_start,
    output logic [7:0]  o_op_index,
    output logic [8:0]  o_split_count,
    output logic [2:0]  o_error_code,
    output logic        o_last_op
);

    localparam int AW = LENGTH_BITS + 1;
    localparam int PW = LENGTH_BITS + 5;
    localparam int OW = (LENGTH_BITS > OUT_LEN_BITS) ? LENGTH_BITS : OUT_LEN_BITS;
    localparam logic [AW-1:0] LEN_MAX  = AW'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [AW-1:0] LEN_OVER = AW'(64'd1 << LENGTH_BITS);
    localparam logic [COUNT_BITS-1:0] OPS_LIMIT = COUNT_BITS'(MAX_OPS);

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_first;
    logic        r_in_last;
    logic [31:0] r_in_start;
    logic        r_in_indels;

    // Parser state
    logic [AW-1:0]         r_acc;
    logic                  r_seen;
    logic [31:0]           r_pos;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] r_splits;
    logic                  r_indels;
    logic                  r_drop;

    logic [AW-1:0]         n_acc;
    logic                  n_seen;
    logic [31:0]           n_pos;
    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS-1:0] n_splits;
    logic                  n_drop;

    // Result register
    logic                    r_out_valid;
    logic [OUT_LEN_BITS-1:0] r_out_len;
    t_op_code                r_out_code;
    logic [31:0]             r_out_ref;
    logic [7:0]              r_out_index;
    logic [COUNT_BITS-1:0]   r_out_splits;
    t_err_code               r_out_err;
    logic                    r_out_last;

    // Working values of the decode stage
    logic                  out_free;
    logic                  fire;
    logic [AW-1:0]         cur_acc;
    logic                  cur_seen;
    logic [31:0]           cur_pos;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] cur_splits;
    logic                  cur_indels;
    logic                  cur_drop;
    logic                  is_digit;
    logic [PW-1:0]         dig_prod;
    logic [AW-1:0]         dig_acc;
    logic                  ops_full;
    t_op_code              dec_code;
    logic                  dec_ok;
    logic [32:0]           pos_sum;
    logic                  res_valid;
    t_op_code              res_code;
    t_err_code             res_err;
    logic                  res_last;
    logic [COUNT_BITS-1:0] res_splits;
    logic [AW-1:0]         res_acc;
    logic [LENGTH_BITS-1:0] res_len;
    logic [OW-1:0]         res_len_ext;

    // Handshake: the result register frees when empty or being taken.
    assign out_free = !r_out_valid || i_ready;
    assign fire     = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_char   <= i_character;
            r_in_first  <= i_first_char;
            r_in_last   <= i_last_char;
            r_in_start  <= i_start_position;
            r_in_indels <= i_allow_indels;
        end
    end

    // A first character reloads the string context before it is decoded.
    always_comb begin
        cur_acc    = r_in_first ? '0 : r_acc;
        cur_seen   = r_in_first ? 1'b0 : r_seen;
        cur_pos    = r_in_first ? r_in_start : r_pos;
        cur_count  = r_in_first ? '0 : r_count;
        cur_splits = r_in_first ? '0 : r_splits;
        cur_indels = r_in_first ? r_in_indels : r_indels;
        cur_drop   = r_in_first ? 1'b0 : r_drop;
    end

    // Decimal accumulation: acc * 10 + digit, saturating one above the maximum.
    always_comb begin
        is_digit = (r_in_char >= CH_ZERO) && (r_in_char <= CH_NINE);
        dig_prod = (PW'(cur_acc) << 3) + (PW'(cur_acc) << 1)
                 + PW'(r_in_char - CH_ZERO);
        dig_acc  = (dig_prod > PW'(LEN_MAX)) ? LEN_OVER : AW'(dig_prod);
        ops_full = cur_count >= OPS_LIMIT;
    end

    // Code letter decode.
    always_comb begin
        dec_code = OP_M;
        dec_ok   = 1'b1;
        case (r_in_char)
            CH_M:    dec_code = OP_M;
            CH_I:    dec_code = OP_I;
            CH_D:    dec_code = OP_D;
            CH_N:    dec_code = OP_N;
            CH_S:    dec_code = OP_S;
            default: dec_ok   = 1'b0;
        endcase
    end

    // Saturating reference advance by the current run length.
    assign pos_sum = {1'b0, cur_pos} + 33'(cur_acc[LENGTH_BITS-1:0]);

    // Main decode: next state and the result, if any.
    always_comb begin
        n_acc      = cur_acc;
        n_seen     = cur_seen;
        n_pos      = cur_pos;
        n_count    = cur_count;
        n_splits   = cur_splits;
        n_drop     = cur_drop;
        res_valid  = 1'b0;
        res_code   = OP_M;
        res_err    = ERR_NONE;
        res_last   = 1'b1;
        res_splits = cur_splits;
        res_acc    = cur_acc;
        if (!cur_drop) begin
            if (is_digit) begin
                n_acc  = dig_acc;
                n_seen = 1'b1;
                // Digits left over at the end of the string.
                if (r_in_last) begin
                    res_valid = 1'b1;
                    res_acc   = dig_acc;
                    res_err   = ops_full ? ERR_OPS : ERR_CODE;
                    n_drop    = 1'b1;
                end
            end else if (ops_full) begin
                res_valid = 1'b1;
                res_err   = ERR_OPS;
                n_drop    = 1'b1;
            end else if (!cur_seen || (cur_acc == '0) || cur_acc[LENGTH_BITS]) begin
                res_valid = 1'b1;
                res_err   = ERR_LENGTH;
                n_drop    = 1'b1;
            end else if (!dec_ok) begin
                res_valid = 1'b1;
                res_err   = ERR_CODE;
                n_drop    = 1'b1;
            end else if (!cur_indels && ((dec_code == OP_I) || (dec_code == OP_D))) begin
                res_valid = 1'b1;
                res_err   = ERR_INDEL;
                n_drop    = 1'b1;
            end else begin
                // A well-formed operation.
                res_valid = 1'b1;
                res_code  = dec_code;
                res_last  = r_in_last;
                if (dec_code == OP_N) begin
                    res_splits = cur_splits + 1'b1;
                    n_splits   = cur_splits + 1'b1;
                end
                if ((dec_code == OP_M) || (dec_code == OP_D) || (dec_code == OP_N)) begin
                    n_pos = pos_sum[32] ? '1 : pos_sum[31:0];
                end
                n_count = cur_count + 1'b1;
                n_acc   = '0;
                n_seen  = 1'b0;
                n_drop  = r_in_last;
            end
        end
        res_len     = res_acc[LENGTH_BITS] ? '1 : res_acc[LENGTH_BITS-1:0];
        res_len_ext = OW'(res_len);
    end

    // Parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_seen   <= 1'b0;
            r_pos    <= '0;
            r_count  <= '0;
            r_splits <= '0;
            r_indels <= 1'b0;
            r_drop   <= 1'b1;
        end else if (fire) begin
            r_acc    <= n_acc;
            r_seen   <= n_seen;
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_splits <= n_splits;
            r_indels <= cur_indels;
            r_drop   <= n_drop;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out_len    <= res_len_ext[OUT_LEN_BITS-1:0];
            r_out_code   <= res_code;
            r_out_ref    <= cur_pos;
            r_out_index  <= cur_count[7:0];
            r_out_splits <= res_splits;
            r_out_err    <= res_err;
            r_out_last   <= res_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_op_length   = r_out_len;
    assign o_op_code     = r_out_code;
    assign o_ref_start   = r_out_ref;
    assign o_op_index    = r_out_index;
    assign o_split_count = r_out_splits;
    assign o_error_code  = r_out_err;
    assign o_last_op     = r_out_last;

`ifndef NO_ASSERTIONS
    // An error result always closes its string.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_err != ERR_NONE)) |-> r_out_last)
        else $error("error result without last_op");

    // An error result carries the M code.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_err != ERR_NONE)) |-> (r_out_code == OP_M))
        else $error("error result with non-M code");

    // A good result never counts more splits than operations so far.
    a_split_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_err == ERR_NONE))
            |-> (r_out_splits <= (COUNT_BITS'(r_out_index) + 1'b1)))
        else $error("split count exceeds operation count");

    // The operation counter never passes the limit.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OPS_LIMIT)
        else $error("operation count beyond limit");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for cigar_string_tokenizer_top: directed, limit and random CIGAR
// strings are streamed in while a scoreboard predicts every decoded operation.
// Depends on cst_pkg and the tokenizer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    localparam int              OP_LIMIT  = 256;
    localparam logic [28:0]     LEN_LIMIT = 29'h0FFF_FFFF;

    // One character request as it crosses the input channel.
    typedef struct {
        logic [7:0]  ch;
        logic        first;
        logic        last;
        logic [31:0] start;
        logic        allow;
    } t_char_req;

    // One decoded operation as it crosses the output channel.
    typedef struct {
        logic [27:0] op_length;
        t_op_code    op_code;
        logic [31:0] ref_start;
        logic [7:0]  op_index;
        logic [8:0]  split_count;
        t_err_code   error_code;
        logic        last_op;
    } t_cigar_op;

    // Tracks the tokenizer state and holds the operations still owed by the block.
    class cigar_scoreboard;
        logic [28:0] run_length  = '0;
        logic        have_digits = 1'b0;
        logic [31:0] ref_pos     = '0;
        logic [8:0]  op_count    = '0;
        logic [8:0]  n_splits    = '0;
        logic        indels_ok   = 1'b0;
        logic        skipping    = 1'b1;
        t_cigar_op   expected_ops[$];
        int          failures      = 0;
        int          ops_checked   = 0;
        int          error_reports = 0;

        function int pending();
            return expected_ops.size();
        endfunction

        function void record(t_op_code code, t_err_code err, logic last);
            t_cigar_op op;
            op.op_length   = (run_length > LEN_LIMIT) ? LEN_LIMIT[27:0] : run_length[27:0];
            op.op_code     = code;
            op.ref_start   = ref_pos;
            op.op_index    = op_count[7:0];
            op.split_count = n_splits;
            op.error_code  = err;
            op.last_op     = last;
            expected_ops.push_back(op);
        endfunction

        // An error closes the string: one report, then the remainder is ignored.
        function void report_error(t_err_code err);
            record(OP_M, err, 1'b1);
            skipping = 1'b1;
        endfunction

        // Notes an accepted character request and predicts what it produces.
        function void note_request(t_char_req r);
            logic [63:0] grown;
            logic [63:0] pos;
            t_op_code    code;
            logic        known;
            if (r.first) begin
                run_length  = '0;
                have_digits = 1'b0;
                ref_pos     = r.start;
                op_count    = '0;
                n_splits    = '0;
                indels_ok   = r.allow;
                skipping    = 1'b0;
            end
            if (skipping) return;

            // Digits extend the run length, which sticks just above the limit on overflow.
            if (r.ch >= CH_ZERO && r.ch <= CH_NINE) begin
                grown = 64'(run_length) * 64'd10 + 64'(r.ch - CH_ZERO);
                run_length  = (grown > 64'(LEN_LIMIT)) ? LEN_LIMIT + 29'd1 : grown[28:0];
                have_digits = 1'b1;
                if (r.last) report_error((op_count >= OP_LIMIT) ? ERR_OPS : ERR_CODE);
                return;
            end

            // Checks at a code letter, in priority order.
            if (op_count >= OP_LIMIT) begin
                report_error(ERR_OPS);
                return;
            end
            if (!have_digits || run_length == '0 || run_length > LEN_LIMIT) begin
                report_error(ERR_LENGTH);
                return;
            end
            known = 1'b1;
            code  = OP_M;
            case (r.ch)
                CH_M: code = OP_M;
                CH_I: code = OP_I;
                CH_D: code = OP_D;
                CH_N: code = OP_N;
                CH_S: code = OP_S;
                default: known = 1'b0;
            endcase
            if (!known) begin
                report_error(ERR_CODE);
                return;
            end
            if (!indels_ok && (code == OP_I || code == OP_D)) begin
                report_error(ERR_INDEL);
                return;
            end

            // A good operation; M, D and N move along the reference.
            if (code == OP_N) n_splits++;
            record(code, ERR_NONE, r.last);
            if (code inside {OP_M, OP_D, OP_N}) begin
                pos     = 64'(ref_pos) + 64'(run_length);
                ref_pos = (pos > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pos[31:0];
            end
            op_count++;
            run_length  = '0;
            have_digits = 1'b0;
            if (r.last) skipping = 1'b1;
        endfunction

        // Compares a delivered operation with the oldest one predicted.
        function void check_result(t_cigar_op got);
            t_cigar_op want;
            logic      bad;
            if (expected_ops.size() == 0) begin
                $error("Unexpected operation: code %0d, length %0d, error code %0d",
                       got.op_code, got.op_length, got.error_code);
                failures++;
                return;
            end
            want = expected_ops.pop_front();
            bad  = 1'b0;
            if (got.op_length !== want.op_length) begin
                $error("op_length: expected %0d, got %0d", want.op_length, got.op_length);
                bad = 1'b1;
            end
            if (got.op_code !== want.op_code) begin
                $error("op_code: expected %0d, got %0d", want.op_code, got.op_code);
                bad = 1'b1;
            end
            if (got.ref_start !== want.ref_start) begin
                $error("ref_start: expected %0d, got %0d", want.ref_start, got.ref_start);
                bad = 1'b1;
            end
            if (got.op_index !== want.op_index) begin
                $error("op_index: expected %0d, got %0d", want.op_index, got.op_index);
                bad = 1'b1;
            end
            if (got.split_count !== want.split_count) begin
                $error("split_count: expected %0d, got %0d", want.split_count, got.split_count);
                bad = 1'b1;
            end
            if (got.error_code !== want.error_code) begin
                $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
                bad = 1'b1;
            end
            if (got.last_op !== want.last_op) begin
                $error("last_op: expected %0d, got %0d", want.last_op, got.last_op);
                bad = 1'b1;
            end
            if (bad) failures++;
            ops_checked++;
            if (want.error_code != ERR_NONE) error_reports++;
        endfunction
    endclass

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_ready;
    logic [7:0]  i_character      = '0;
    logic        i_first_char     = 1'b0;
    logic        i_last_char      = 1'b0;
    logic [31:0] i_start_position = '0;
    logic        i_allow_indels   = 1'b0;
    logic        o_valid;
    logic        i_ready          = 1'b0;
    logic [27:0] o_op_length;
    logic [2:0]  o_op_code;
    logic [31:0] o_ref_start;
    logic [7:0]  o_op_index;
    logic [8:0]  o_split_count;
    logic [2:0]  o_error_code;
    logic        o_last_op;

    cigar_scoreboard board = new;

    // Idling state for both sides, and run statistics.
    logic src_calm      = 1'b0;
    logic rx_calm       = 1'b0;
    int   chars_sent    = 0;
    int   strings_sent  = 0;

    cigar_string_tokenizer_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_character      (i_character),
        .i_first_char     (i_first_char),
        .i_last_char      (i_last_char),
        .i_start_position (i_start_position),
        .i_allow_indels   (i_allow_indels),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_op_length      (o_op_length),
        .o_op_code        (o_op_code),
        .o_ref_start      (o_ref_start),
        .o_op_index       (o_op_index),
        .o_split_count    (o_split_count),
        .o_error_code     (o_error_code),
        .o_last_op        (o_last_op)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned draw_wait(logic calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // Drives one character request and waits until the block takes it.
    task automatic push_char(t_char_req r);
        int unsigned gap;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_character      <= r.ch;
        i_first_char     <= r.first;
        i_last_char      <= r.last;
        i_start_position <= r.start;
        i_allow_indels   <= r.allow;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_request(r);
        chars_sent++;
    endtask

    task automatic send_bytes(logic [7:0] text[$], logic [31:0] start, logic allow,
                              logic opens, int last_at);
        t_char_req r;
        if (opens) strings_sent++;
        foreach (text[i]) begin
            r.ch    = text[i];
            r.first = opens && (i == 0);
            r.last  = (i == last_at);
            r.start = start;
            r.allow = allow;
            push_char(r);
        end
    endtask

    // Sends a written-out string; an unclosed one carries no last marker.
    task automatic send_cigar(string s, logic [31:0] start, logic allow, logic closed);
        logic [7:0] text[$];
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
        send_bytes(text, start, allow, 1'b1, closed ? text.size() - 1 : -1);
    endtask

    // Appends a run length: mostly short, sometimes huge, zero, missing or overflowing.
    function automatic void append_length(ref logic [7:0] text[$]);
        int unsigned     pick;
        longint unsigned len;
        string           digits;
        pick = $urandom_range(0, 19);
        if (pick == 0) return;
        if (pick == 1)      len = 0;
        else if (pick == 2) len = LEN_LIMIT;
        else if (pick == 3) len = 64'd268435456 + $urandom;
        else if (pick <= 5) len = $urandom_range(100, LEN_LIMIT);
        else                len = $urandom_range(1, 99);
        digits = $sformatf("%0d", len);
        if ($urandom_range(0, 15) == 0) text.push_back(CH_ZERO);
        foreach (digits[i]) text.push_back(digits[i]);
    endfunction

    // Picks a code letter; indels are mostly avoided where they are not allowed.
    function automatic logic [7:0] pick_code(logic allow);
        logic [7:0] letters[5];
        int unsigned idx;
        letters = '{CH_M, CH_I, CH_D, CH_N, CH_S};
        idx = $urandom_range(0, 4);
        if (!allow && (idx == 1 || idx == 2) && $urandom_range(0, 3) != 0) idx = 0;
        return letters[idx];
    endfunction

    // A well-formed string with random content, broken in a third of cases.
    task automatic send_random_string();
        logic [7:0]  text[$];
        int          n_ops;
        int          last_at;
        logic        allow;
        logic [31:0] start;
        n_ops = $urandom_range(1, 6);
        allow = ($urandom_range(0, 3) != 0);
        start = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom;
        for (int k = 0; k < n_ops; k++) begin
            append_length(text);
            text.push_back(pick_code(allow));
        end
        last_at = text.size() - 1;
        case ($urandom_range(0, 11))
            0: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
                repeat ($urandom_range(1, 3)) text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                last_at = text.size() - 1;
            end
            2: begin
                text    = text[0:$urandom_range(0, text.size() - 1)];
                last_at = -1;
            end
            3: last_at = $urandom_range(0, text.size() - 1);
            default: ;
        endcase
        send_bytes(text, start, allow, 1'b1, last_at);
    endtask

    // Runs a string past the operation limit, ending on a letter or on a trailing digit.
    task automatic send_op_limit_string(logic end_on_digit);
        logic [7:0] text[$];
        repeat (OP_LIMIT) begin
            if (end_on_digit) begin
                text.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
                text.push_back(pick_code(1'b1));
            end else begin
                text.push_back(CH_NINE);
                text.push_back(CH_N);
            end
        end
        if (end_on_digit) begin
            text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end else begin
            text.push_back(8'(CH_ZERO + 5));
            text.push_back(CH_M);
        end
        send_bytes(text, $urandom, 1'b1, 1'b1, text.size() - 1);
    endtask

    // Holds back further requests until every predicted operation has arrived.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Receiver: stalls a random number of cycles before taking each result.
    initial begin
        int unsigned stall;
        forever begin
            if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
            stall = draw_wait(rx_calm);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_cigar_op seen;
        if (i_rst_n && o_valid && i_ready) begin
            seen.op_length   = o_op_length;
            seen.op_code     = t_op_code'(o_op_code);
            seen.ref_start   = o_ref_start;
            seen.op_index    = o_op_index;
            seen.split_count = o_split_count;
            seen.error_code  = t_err_code'(o_error_code);
            seen.last_op     = o_last_op;
            board.check_result(seen);
        end
    end

    // Main stimulus.
    initial begin
        logic [7:0] noise[$];
        logic       drained_once;
        drained_once = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Characters before any string opens must be ignored.
        noise = '{8'(CH_ZERO + 7), CH_M};
        send_bytes(noise, 32'd0, 1'b1, 1'b0, 1);

        // Every code, with the reference position saturating at the top.
        send_cigar("3M2I4D1N5S", 32'hFFFF_FFFE, 1'b1, 1'b1);
        // Letter with no length, opening and closing on one character.
        send_cigar("M", 32'd0, 1'b0, 1'b1);
        // Insertion where indels are not allowed.
        send_cigar("2I", 32'h1234_5678, 1'b0, 1'b1);
        // Unknown code letter.
        send_cigar("5X", 32'h0000_0100, 1'b1, 1'b1);
        // Digits left over at the end of the string.
        send_cigar("5M3", 32'h8000_0000, 1'b1, 1'b1);
        // An unfinished string is abandoned by the next one, whose length overflows.
        send_cigar("4", 32'h0000_0010, 1'b1, 1'b0);
        send_cigar("999999999M", 32'h0000_0020, 1'b0, 1'b1);

        // Operation limit reached at a letter and at a trailing digit.
        send_op_limit_string(1'b0);
        send_op_limit_string(1'b1);

        // Random strings, with a full drain part way through.
        while (chars_sent < 1300) begin
            if (!drained_once && chars_sent >= 1180) begin
                hold_until_drained();
                drained_once = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) src_calm = !src_calm;
            send_random_string();
            if ($urandom_range(0, 9) == 0) begin
                noise = {};
                repeat ($urandom_range(1, 3)) noise.push_back(8'($urandom_range(0, 255)));
                send_bytes(noise, $urandom, 1'($urandom_range(0, 1)), 1'b0, -1);
            end
        end

        // Let the last results through, then allow for the pipeline.
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Run summary: %0d characters accepted in %0d strings; %0d operations checked,",
                 chars_sent, strings_sent, board.ops_checked);
        $display("  %0d of them error reports, including both operation-limit cases.",
                 board.error_reports);
        if (board.failures == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4_000_000;
        $display("Timeout with %0d operations still outstanding", board.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
